FILE: rtl/core/grs_pkg.sv
// Shared types and constants for the group reverse stream block.
package grs_pkg;

  // Width of one data value.
  localparam int VALUE_W = 32;

  // Width and reset value of the group size register.
  localparam int GROUP_SIZE_W = 5;
  localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = 5'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic read;
    logic advance;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_results;
    logic last;
  } ctrl_status_t;

endpackage

FILE: rtl/core/grs_ctrl.sv
// Controller state machine for the group reverse stream block.
module grs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  grs_pkg::ctrl_status_t status,
  output grs_pkg::ctrl_cmd_t    cmd
);

  grs_pkg::state_t state;
  grs_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: an accepted beat that releases results starts a burst, and
  // each result is read from the store and then shown until taken.
  always_comb begin
    state_next = state;
    case (state)
      grs_pkg::ST_IDLE: begin
        if (in_valid && status.has_results) begin
          state_next = grs_pkg::ST_READ;
        end
      end
      grs_pkg::ST_READ: begin
        state_next = grs_pkg::ST_SHOW;
      end
      grs_pkg::ST_SHOW: begin
        if (out_ready) begin
          state_next = status.last ? grs_pkg::ST_IDLE : grs_pkg::ST_READ;
        end
      end
      default: begin
        state_next = grs_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: handshakes and datapath commands.
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.accept  = 1'b0;
    cmd.read    = 1'b0;
    cmd.advance = 1'b0;
    case (state)
      grs_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      grs_pkg::ST_READ: begin
        cmd.read = 1'b1;
      end
      grs_pkg::ST_SHOW: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/grs_datapath.sv
// Datapath for the group reverse stream block: group store, counters and output register.
module grs_datapath #(
  parameter int MAX_GROUP = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                group_size_write,
  input  logic [grs_pkg::GROUP_SIZE_W-1:0]    group_size,
  input  logic signed [grs_pkg::VALUE_W-1:0]  item_value,
  input  logic                                item_final,
  input  grs_pkg::ctrl_cmd_t                  cmd,
  output grs_pkg::ctrl_status_t               status,
  output logic signed [grs_pkg::VALUE_W-1:0]  out_value,
  output logic                                run_end,
  output logic                                sequence_end
);

  localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int EW = (CW > grs_pkg::GROUP_SIZE_W) ? CW : grs_pkg::GROUP_SIZE_W;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_GROUP);
  localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_GROUP - 1);

  logic [grs_pkg::GROUP_SIZE_W-1:0] size_reg;
  logic [CW-1:0]                    fill_count;
  logic [CW-1:0]                    run_len;
  logic [IW-1:0]                    pos;
  logic                             reverse;
  logic                             seq_final;
  logic [grs_pkg::VALUE_W-1:0]      rd_data;
  logic [grs_pkg::VALUE_W-1:0]      group_store [MAX_GROUP];

  logic [CW-1:0] eff_size;
  logic [IW-1:0] wr_idx;
  logic [CW-1:0] held;
  logic          full_group;
  logic [IW-1:0] rd_addr;
  logic          last;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= grs_pkg::GROUP_SIZE_RESET;
    end else if (group_size_write) begin
      size_reg <= group_size;
    end
  end

  // Effective group size: zero acts as one, large values saturate.
  always_comb begin
    if (size_reg == '0) begin
      eff_size = CW'(1);
    end else if (EW'(size_reg) > EW'(MAX_GROUP)) begin
      eff_size = MAX_COUNT;
    end else begin
      eff_size = CW'(size_reg);
    end
  end

  // Store slot for the incoming beat and the count held after it.
  always_comb begin
    wr_idx     = (fill_count >= MAX_COUNT) ? LAST_IDX : IW'(fill_count);
    held       = CW'(wr_idx) + CW'(1);
    full_group = (held >= eff_size);
  end

  assign status.has_results = full_group || item_final;

  // Fill count and burst bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      pos        <= '0;
    end else if (cmd.accept) begin
      pos <= '0;
      if (full_group || item_final) begin
        fill_count <= '0;
      end else begin
        fill_count <= held;
      end
    end else if (cmd.advance) begin
      pos <= pos + IW'(1);
    end
  end

  // Burst descriptor, captured with each accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      run_len   <= held;
      reverse   <= full_group;
      seq_final <= item_final;
    end
  end

  // Read order: newest first for a full group, arrival order otherwise.
  always_comb begin
    rd_addr = reverse ? IW'(run_len - CW'(1) - CW'(pos)) : pos;
    last    = (CW'(pos) == run_len - CW'(1));
  end

  assign status.last = last;

  // Group store with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      group_store[wr_idx] <= item_value;
    end
    if (cmd.read) begin
      rd_data <= group_store[rd_addr];
    end
  end

  // Result beat fields.
  assign out_value    = $signed(rd_data);
  assign run_end      = last;
  assign sequence_end = last && seq_final;

endmodule

FILE: rtl/core/group_reverse_stream_top.sv
// Top level of the group reverse stream block.
//
// Input channel: in_valid/in_ready carry one value (item_value) per beat,
// with item_final marking the last value of a sequence. Output channel:
// out_valid/out_ready carry one value (out_value) per beat, with run_end on
// the last result released by one input beat and sequence_end on the last
// result of the sequence.
// Every complete group of group_size values leaves newest first; a partial
// group cut short by item_final leaves in arrival order.
// An input beat that releases no results is only stored in the group. A beat
// that releases results keeps the input closed: each result is first read
// from the group store into the output register and shown until taken.
// A stalled receiver holds the shown result and its flags unchanged; the
// input stays closed until the burst is finished.
// Reset empties the group, returns the block to idle and sets group_size to 2.
// The user must write group_size via group_size_write only while idle; the block does not enforce it.
module group_reverse_stream_top #(
  parameter int MAX_GROUP = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                group_size_write,
  input  logic [grs_pkg::GROUP_SIZE_W-1:0]    group_size,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [grs_pkg::VALUE_W-1:0]  item_value,
  input  logic                                item_final,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [grs_pkg::VALUE_W-1:0]  out_value,
  output logic                                run_end,
  output logic                                sequence_end
);

  grs_pkg::ctrl_cmd_t    cmd;
  grs_pkg::ctrl_status_t status;

  // Controller.
  grs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  grs_datapath #(
    .MAX_GROUP (MAX_GROUP)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .group_size_write (group_size_write),
    .group_size       (group_size),
    .item_value       (item_value),
    .item_final       (item_final),
    .cmd              (cmd),
    .status           (status),
    .out_value        (out_value),
    .run_end          (run_end),
    .sequence_end     (sequence_end)
  );

endmodule

FILE: rtl/core/grs_checker.sv
// Port-level checker for the group reverse stream block, with its bind.
module grs_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                item_final,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [grs_pkg::VALUE_W-1:0]  out_value,
  input logic                                run_end,
  input logic                                sequence_end
);

  // A stalled result beat keeps its value and flags.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(run_end)
      && $stable(sequence_end))
    else $error("stalled result beat changed");

  // The end of a sequence is always the end of a run.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && sequence_end |-> run_end)
    else $error("sequence_end without run_end");

  // The input is closed while a result is shown.
  assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input open during a result burst");

  // A final beat always releases results, so the input closes behind it.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && item_final |=> !in_ready)
    else $error("final beat released no burst");

endmodule

bind group_reverse_stream_top grs_checker u_grs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .item_final   (item_final),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_value    (out_value),
  .run_end      (run_end),
  .sequence_end (sequence_end)
);

FILE: dv/testbench.sv
// Self-checking testbench for the group reverse stream block.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_GROUP = 16;
  localparam int IDLE_PCT = 9;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 150;

  typedef struct {
    logic signed [grs_pkg::VALUE_W-1:0] value;
    logic is_last;
  } seq_item_t;

  typedef struct {
    logic signed [grs_pkg::VALUE_W-1:0] value;
    logic run_last;
    logic seq_last;
  } reordered_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [grs_pkg::GROUP_SIZE_W-1:0] cfg_size = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [grs_pkg::VALUE_W-1:0] item_value = '0;
  logic item_final = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [grs_pkg::VALUE_W-1:0] out_value;
  logic run_end;
  logic sequence_end;

  // Items waiting to be offered, and reordered values still owed by the block.
  seq_item_t pending_items[$];
  reordered_t owed_values[$];

  // Private copy of the block's state for prediction.
  logic [grs_pkg::GROUP_SIZE_W-1:0] size_setting = grs_pkg::GROUP_SIZE_RESET;
  logic signed [grs_pkg::VALUE_W-1:0] held_values[MAX_GROUP];
  int held_count = 0;

  int mismatch_count = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;

  always #2 clk = ~clk;

  group_reverse_stream_top #(
    .MAX_GROUP(MAX_GROUP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .group_size_write(cfg_write),
    .group_size(cfg_size),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .item_value(item_value),
    .item_final(item_final),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value),
    .run_end(run_end),
    .sequence_end(sequence_end)
  );

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Store one value and work out the burst it releases, if any.
  task automatic predict_reorder(input logic signed [grs_pkg::VALUE_W-1:0] value,
                                 input logic is_last);
    int group_len;
    int n;
    reordered_t r;
    if (size_setting == 0) begin
      group_len = 1;
    end else if (size_setting > MAX_GROUP) begin
      group_len = MAX_GROUP;
    end else begin
      group_len = size_setting;
    end
    if (held_count >= MAX_GROUP) begin
      held_count = MAX_GROUP - 1;
    end
    held_values[held_count] = value;
    held_count++;
    n = held_count;
    if (n >= group_len) begin
      // A complete group (or one cut short by a smaller size) leaves newest first.
      for (int i = 0; i < n; i++) begin
        r.value = held_values[n - 1 - i];
        r.run_last = (i == n - 1);
        r.seq_last = (i == n - 1) && is_last;
        owed_values.push_back(r);
      end
      held_count = 0;
    end else if (is_last) begin
      // A partial group at the end of a sequence leaves in arrival order.
      for (int i = 0; i < n; i++) begin
        r.value = held_values[i];
        r.run_last = (i == n - 1);
        r.seq_last = (i == n - 1);
        owed_values.push_back(r);
      end
      held_count = 0;
    end
  endtask

  // Input driver: offers queued items and predicts on every accepted beat.
  always @(posedge clk) begin : drive_items
    seq_item_t next_item;
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_reorder(item_value, item_final);
      end
      if (!in_valid || in_ready) begin
        offer = (pending_items.size() != 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        if (offer) begin
          next_item = pending_items.pop_front();
          item_value <= next_item.value;
          item_final <= next_item.is_last;
        end
        in_valid <= offer;
      end
    end
  end

  // Output monitor: checks each result beat against the oldest owed value.
  always @(posedge clk) begin : watch_results
    reordered_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_values.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d", out_value));
        end else begin
          want = owed_values.pop_front();
          if (out_value !== want.value) begin
            report_mismatch($sformatf("out_value %0d, expected %0d", out_value, want.value));
          end
          if (run_end !== want.run_last) begin
            report_mismatch($sformatf("run_end %b, expected %b", run_end, want.run_last));
          end
          if (sequence_end !== want.seq_last) begin
            report_mismatch($sformatf("sequence_end %b, expected %b",
                                      sequence_end, want.seq_last));
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: ends the run when no beat has moved for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic write_group_size(input logic [grs_pkg::GROUP_SIZE_W-1:0] size);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_size <= size;
    size_setting = size;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_item(input logic signed [grs_pkg::VALUE_W-1:0] value,
                           input logic is_last);
    seq_item_t it;
    it.value = value;
    it.is_last = is_last;
    pending_items.push_back(it);
  endtask

  // Hold the sender back until every owed result has arrived and the block is quiet.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending_items.size() != 0 || in_valid || owed_values.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [grs_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: pick_value = 32'sh8000_0000;
      1: pick_value = 32'sh7FFF_FFFF;
      2: pick_value = '0;
      3: pick_value = -32'sd1;
      default: pick_value = $urandom();
    endcase
  endfunction

  initial begin : stimulus
    int random_done;
    int phase;
    int count;
    int group_len;
    logic [grs_pkg::GROUP_SIZE_W-1:0] size;
    random_done = 0;
    phase = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset size of two: extreme values, a full group closing the sequence,
    // then a single-item sequence left as a partial group.
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item('0, 1'b0);
    push_item(-32'sd1, 1'b1);
    push_item(32'sd5, 1'b1);
    wait_drained();

    // A zero size behaves as one, so values pass straight through.
    write_group_size('0);
    push_item(32'sd123, 1'b0);
    push_item(-32'sd456, 1'b1);
    wait_drained();

    // An oversized setting saturates; a short sequence leaves in order.
    write_group_size(5'd31);
    push_item(32'sd1, 1'b0);
    push_item(32'sd2, 1'b0);
    push_item(32'sd3, 1'b1);
    wait_drained();

    // Lowering the size with values already held releases them all reversed.
    write_group_size(5'd5);
    for (int i = 0; i < 4; i++) begin
      push_item(32'sd10 + i, 1'b0);
    end
    wait_drained();
    write_group_size(5'd3);
    push_item(32'sd20, 1'b0);
    push_item(32'sd21, 1'b1);
    wait_drained();

    // Random phases, each under its own group size.
    while (random_done < RANDOM_ITEMS) begin
      case (phase)
        0: size = 5'd1;
        1: size = 5'd16;
        2: size = 5'd31;
        3: size = 5'd0;
        4: size = 5'd4;
        default: size = $urandom_range(0, 31);
      endcase
      write_group_size(size);
      if (size == 0) begin
        group_len = 1;
      end else if (size > MAX_GROUP) begin
        group_len = MAX_GROUP;
      end else begin
        group_len = size;
      end
      calm = (phase == 4);
      count = $urandom_range(12, 24);
      for (int i = 0; i < count; i++) begin
        push_item(pick_value(), $urandom_range(0, 2 * group_len) == 0);
      end
      wait_drained();
      calm = 1'b0;
      random_done += count;
      phase++;
    end

    wait_drained();
    if (owed_values.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", owed_values.size()));
    end
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
